// ----- rtl/bppu_pkg.sv -----
// Package for the bitmap palette pixel unpacker.
// Holds command, depth and register codes, the queue and pixel structs.
// No dependencies.
package bppu_pkg;

  localparam int CoordLimit = 4096;

  localparam logic [1:0] CMD_PAL_WR = 2'd0;
  localparam logic [1:0] CMD_LINE   = 2'd1;
  localparam logic [1:0] CMD_DATA   = 2'd2;

  localparam logic [2:0] DEPTH_1BPP  = 3'd0;
  localparam logic [2:0] DEPTH_2BPP  = 3'd1;
  localparam logic [2:0] DEPTH_4BPP  = 3'd2;
  localparam logic [2:0] DEPTH_8BPP  = 3'd3;
  localparam logic [2:0] DEPTH_24BPP = 3'd4;

  localparam logic [2:0] REG_DEPTH_MODE      = 3'd0;
  localparam logic [2:0] REG_FIRST_COLUMN    = 3'd1;
  localparam logic [2:0] REG_END_COLUMN      = 3'd2;
  localparam logic [2:0] REG_START_BIT_SKIP  = 3'd3;
  localparam logic [2:0] REG_TRANSPARENT_KEY = 3'd4;
  localparam logic [2:0] REG_KEY_ENABLE      = 3'd5;

  typedef enum logic [1:0] {
    OP_PAL_WR,
    OP_LINE,
    OP_DATA
  } op_t;

  typedef struct packed {
    logic [2:0]  depth_mode;
    logic [11:0] first_column;
    logic [12:0] end_column;
    logic [2:0]  start_bit_skip;
    logic [23:0] transparent_key;
    logic        key_enable;
  } cfg_t;

  // code carries the data byte or the palette index, depending on op
  typedef struct packed {
    op_t         op;
    logic [7:0]  code;
    logic [23:0] color;
    logic [11:0] row;
  } q_entry_t;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [23:0] color;
    logic        byte_end;
  } cand_t;

endpackage

// ----- rtl/bppu_front.sv -----
// Front end: accepts transactions, classifies them and queues known ones.
// Depends on bppu_pkg.
module bppu_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          command,
  input  logic [7:0]          data_byte,
  input  logic [7:0]          palette_index,
  input  logic [23:0]         palette_color,
  input  logic [11:0]         line_row,
  output logic                q_valid,
  output bppu_pkg::q_entry_t  q_head,
  input  logic                q_pop
);
  import bppu_pkg::*;

  localparam int QDepth = 4;
  localparam int PW     = $clog2(QDepth);

  q_entry_t         fifo [QDepth];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;
  logic [PW:0]      count_next;
  q_entry_t         entry;
  logic             known;
  logic             push;
  logic             pop;

  always_comb begin
    entry.op    = OP_DATA;
    entry.code  = data_byte;
    entry.color = palette_color;
    entry.row   = line_row;
    known       = 1'b1;
    unique case (command)
      CMD_PAL_WR: begin
        entry.op   = OP_PAL_WR;
        entry.code = palette_index;
      end
      CMD_LINE: entry.op = OP_LINE;
      CMD_DATA: entry.op = OP_DATA;
      default:  known = 1'b0;
    endcase
  end

  assign in_stall = (count == (PW+1)'(QDepth));
  assign push     = in_valid && !in_stall && known;
  assign pop      = q_pop && q_valid;
  assign q_valid  = (count != '0);
  assign q_head   = fifo[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= entry;
    end
  end

endmodule

// ----- rtl/bppu_unpack.sv -----
// Back end sequencer: line state, byte unpacking and palette lookup.
// Emits pixel candidates, held until taken. Depends on bppu_pkg.
module bppu_unpack #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  bppu_pkg::cfg_t      cfg,
  input  logic                q_valid,
  input  bppu_pkg::q_entry_t  q_head,
  output logic                q_pop,
  output logic                cand_valid,
  output bppu_pkg::cand_t     cand,
  input  logic                cand_ready
);
  import bppu_pkg::*;

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  logic [23:0] palette [PALETTE_DEPTH];

  logic        line_active;
  logic        line_active_next;
  logic [12:0] column_counter;
  logic [12:0] column_counter_next;
  logic [11:0] current_row;
  logic [11:0] current_row_next;
  logic [3:0]  bit_pos;
  logic [3:0]  bit_pos_next;
  logic [1:0]  byte_phase;
  logic [1:0]  byte_phase_next;
  logic [15:0] partial_color;
  logic [15:0] partial_color_next;

  logic        r_valid;
  logic [11:0] r_x;
  logic [11:0] r_y;
  logic        r_direct;
  logic [23:0] r_dir_color;
  logic        r_oob;
  logic        r_byte_end;
  logic [23:0] rd_data;

  logic        go;
  logic        issue;
  logic        issue_pal;
  logic [7:0]  issue_idx;
  logic [23:0] issue_color;
  logic        issue_end;
  logic        pal_we;

  logic [12:0] end_eff;
  logic [3:0]  bpp;
  logic [4:0]  pos_sum;
  logic        fits;
  logic [3:0]  pos_adv;
  logic        next_fits;
  logic [12:0] col_inc;
  logic        active_after;
  logic [7:0]  shl;
  logic [7:0]  sub_idx;

  assign end_eff = ({4'd0, cfg.end_column} < 17'(CoordLimit)) ? cfg.end_column
                                                                : 13'(CoordLimit);
  assign bpp          = 4'd1 << cfg.depth_mode[1:0];
  assign pos_sum      = {1'b0, bit_pos} + {1'b0, bpp};
  assign fits         = (pos_sum <= 5'd8);
  assign pos_adv      = pos_sum[3:0];
  assign next_fits    = (({1'b0, pos_adv} + {1'b0, bpp}) <= 5'd8);
  assign col_inc      = column_counter + 13'd1;
  assign active_after = (col_inc < end_eff);
  assign shl          = q_head.code << bit_pos;
  assign sub_idx      = shl >> (4'd8 - bpp);

  assign go = q_valid && (!r_valid || cand_ready);

  always_comb begin
    q_pop               = 1'b0;
    issue               = 1'b0;
    issue_pal           = 1'b0;
    issue_idx           = q_head.code;
    issue_color         = {q_head.code, partial_color};
    issue_end           = 1'b1;
    pal_we              = 1'b0;
    line_active_next    = line_active;
    column_counter_next = column_counter;
    current_row_next    = current_row;
    bit_pos_next        = bit_pos;
    byte_phase_next     = byte_phase;
    partial_color_next  = partial_color;
    if (go) begin
      q_pop = 1'b1;
      unique case (q_head.op)
        OP_PAL_WR: begin
          pal_we = ({1'b0, q_head.code} < 9'(PALETTE_DEPTH));
        end
        OP_LINE: begin
          current_row_next    = q_head.row;
          column_counter_next = {1'b0, cfg.first_column};
          byte_phase_next     = 2'd0;
          partial_color_next  = '0;
          bit_pos_next        = {1'b0, cfg.start_bit_skip};
          line_active_next    = ({1'b0, cfg.first_column} < end_eff);
        end
        OP_DATA: begin
          if (line_active) begin
            unique case (cfg.depth_mode) inside
              DEPTH_1BPP, DEPTH_2BPP, DEPTH_4BPP: begin
                bit_pos_next = 4'd0;
                if (fits) begin
                  issue               = 1'b1;
                  issue_pal           = 1'b1;
                  issue_idx           = sub_idx;
                  column_counter_next = col_inc;
                  line_active_next    = active_after;
                  issue_end           = !active_after || !next_fits;
                  if (active_after && next_fits) begin
                    q_pop        = 1'b0;
                    bit_pos_next = pos_adv;
                  end
                end
              end
              DEPTH_8BPP: begin
                issue               = 1'b1;
                issue_pal           = 1'b1;
                column_counter_next = col_inc;
                line_active_next    = active_after;
              end
              DEPTH_24BPP: begin
                unique case (byte_phase)
                  2'd0: begin
                    partial_color_next = {8'd0, q_head.code};
                    byte_phase_next    = 2'd1;
                  end
                  2'd1: begin
                    partial_color_next = {q_head.code, partial_color[7:0]};
                    byte_phase_next    = 2'd2;
                  end
                  default: begin
                    issue               = 1'b1;
                    byte_phase_next     = 2'd0;
                    partial_color_next  = '0;
                    column_counter_next = col_inc;
                    line_active_next    = active_after;
                  end
                endcase
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active    <= 1'b0;
      column_counter <= '0;
      current_row    <= '0;
      bit_pos        <= '0;
      byte_phase     <= '0;
      partial_color  <= '0;
      r_valid        <= 1'b0;
    end else begin
      line_active    <= line_active_next;
      column_counter <= column_counter_next;
      current_row    <= current_row_next;
      bit_pos        <= bit_pos_next;
      byte_phase     <= byte_phase_next;
      partial_color  <= partial_color_next;
      if (!r_valid || cand_ready) begin
        r_valid <= issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      r_x         <= column_counter[11:0];
      r_y         <= current_row;
      r_direct    <= !issue_pal;
      r_dir_color <= issue_color;
      r_oob       <= ({1'b0, issue_idx} >= 9'(PALETTE_DEPTH));
      r_byte_end  <= issue_end;
    end
  end

  always_ff @(posedge clk) begin
    if (pal_we) begin
      palette[q_head.code[AW-1:0]] <= q_head.color;
    end
    if (issue && issue_pal) begin
      rd_data <= palette[issue_idx[AW-1:0]];
    end
  end

  assign cand_valid    = r_valid;
  assign cand.x        = r_x;
  assign cand.y        = r_y;
  assign cand.color    = r_direct ? r_dir_color : (r_oob ? 24'd0 : rd_data);
  assign cand.byte_end = r_byte_end;

endmodule

// ----- rtl/bppu_tail.sv -----
// Output stage: drops transparent pixels, marks the last kept pixel of
// each byte and registers the result. Depends on bppu_pkg.
module bppu_tail (
  input  logic             clk,
  input  logic             rst,
  input  bppu_pkg::cfg_t   cfg,
  input  logic             cand_valid,
  input  bppu_pkg::cand_t  cand,
  output logic             cand_ready,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [11:0]      pixel_x,
  output logic [11:0]      pixel_y,
  output logic [23:0]      pixel_color,
  output logic             last_of_byte
);
  import bppu_pkg::*;

  logic        keep;
  logic        o_free;
  logic        take;
  logic        h_valid;
  logic        h_last;
  logic [11:0] h_x;
  logic [11:0] h_y;
  logic [23:0] h_color;
  logic        o_load;
  logic        h_load;

  assign keep       = !(cfg.key_enable && (cand.color == cfg.transparent_key));
  assign o_free     = !out_valid || !out_stall;
  assign cand_ready = !h_valid || o_free || (!h_last && !keep);
  assign take       = cand_valid && cand_ready;

  // held pixel leaves once a later kept pixel of its byte arrives, or once
  // it is known to be the byte's last
  assign o_load = h_valid && o_free && (h_last || (take && keep));
  assign h_load = take && keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid   <= 1'b0;
      h_last    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (o_load) begin
        out_valid <= 1'b1;
      end else if (o_free) begin
        out_valid <= 1'b0;
      end
      if (h_load) begin
        h_valid <= 1'b1;
        h_last  <= cand.byte_end;
      end else if (o_load) begin
        h_valid <= 1'b0;
      end else if (take && h_valid && cand.byte_end) begin
        h_last <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      pixel_x      <= h_x;
      pixel_y      <= h_y;
      pixel_color  <= h_color;
      last_of_byte <= h_last;
    end
    if (h_load) begin
      h_x     <= cand.x;
      h_y     <= cand.y;
      h_color <= cand.color;
    end
  end

endmodule

// ----- rtl/bitmap_palette_pixel_unpacker_unit.sv -----
// Top level of the bitmap palette pixel unpacker.
// Holds the configuration registers; instantiates bppu_front, bppu_unpack
// and bppu_tail. Depends on bppu_pkg.
//
// Usage: the host writes registers through cfg_write/cfg_index/cfg_data
// while the block is idle. Input transactions (in_valid/in_stall) carry a
// palette write, a line start with its row, or one bitmap byte. Output
// transactions (out_valid/out_stall) carry one pixel each, with
// last_of_byte set on the final kept pixel of a byte.
// A byte yields up to eight pixels at 1 bpp and one at 8 bpp; at 24 bpp
// three bytes make one pixel. The sequencer stalls while its pixel waits.
// A four-entry queue lets input be taken while the sequencer works.
// A pixel passes from the queue through the sequencer's candidate
// register, the held-pixel register and the output register; a kept pixel
// is held until the next kept pixel of its byte or the byte's end is seen.
// Reset clears the queue, line state and registers (depth 8 bpp); palette
// contents are undefined until written. When out_stall is high the output
// holds, the pipeline fills and in_stall rises once the queue is full.
module bitmap_palette_pixel_unpacker_unit #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  palette_index,
  input  logic [23:0] palette_color,
  input  logic [11:0] line_row,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] pixel_x,
  output logic [11:0] pixel_y,
  output logic [23:0] pixel_color,
  output logic        last_of_byte
);
  import bppu_pkg::*;

  cfg_t     cfg;
  logic     q_valid;
  q_entry_t q_head;
  logic     q_pop;
  logic     cand_valid;
  cand_t    cand;
  logic     cand_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.depth_mode      <= DEPTH_8BPP;
      cfg.first_column    <= '0;
      cfg.end_column      <= '0;
      cfg.start_bit_skip  <= '0;
      cfg.transparent_key <= '0;
      cfg.key_enable      <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DEPTH_MODE:      cfg.depth_mode      <= cfg_data[2:0];
        REG_FIRST_COLUMN:    cfg.first_column    <= cfg_data[11:0];
        REG_END_COLUMN:      cfg.end_column      <= cfg_data[12:0];
        REG_START_BIT_SKIP:  cfg.start_bit_skip  <= cfg_data[2:0];
        REG_TRANSPARENT_KEY: cfg.transparent_key <= cfg_data;
        REG_KEY_ENABLE:      cfg.key_enable      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  bppu_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .data_byte     (data_byte),
    .palette_index (palette_index),
    .palette_color (palette_color),
    .line_row      (line_row),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop)
  );

  bppu_unpack #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_unpack (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .cand_valid (cand_valid),
    .cand       (cand),
    .cand_ready (cand_ready)
  );

  bppu_tail u_tail (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cand_valid   (cand_valid),
    .cand         (cand),
    .cand_ready   (cand_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .pixel_color  (pixel_color),
    .last_of_byte (last_of_byte)
  );

endmodule
